### rtl/mpeg2_header_parser_macros.svh
// Assertion macros for the MPEG-2 header parser
`ifndef MPEG2_HEADER_PARSER_MACROS_SVH
`define MPEG2_HEADER_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MHP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mhp_pkg.sv
// Types and constants shared by the MPEG-2 header parser modules
package mhp_pkg;

	localparam logic [31:0] CODE_SEQ = 32'h0000_01B3;
	localparam logic [31:0] CODE_EXT = 32'h0000_01B5;
	localparam logic [31:0] CODE_PIC = 32'h0000_0100;
	localparam int unsigned SC_BYTES = 4;

	localparam logic [2:0] ST_SEQ_PIC  = 3'd0;
	localparam logic [2:0] ST_SEQ_ONLY = 3'd1;
	localparam logic [2:0] ST_PIC_ONLY = 3'd2;
	localparam logic [2:0] ST_NONE     = 3'd3;
	localparam logic [2:0] ST_SEQ_ERR  = 3'd4;
	localparam logic [2:0] ST_PIC_ERR  = 3'd5;

	localparam logic [3:0] REC_NONE = 4'd0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        seq_valid;
		logic        pic_valid;
		logic [11:0] frame_width;
		logic [11:0] frame_height;
		logic [2:0]  profile_code;
		logic [1:0]  level_code;
		logic        interlaced;
		logic [1:0]  frame_type;
		logic        is_reference;
		logic [15:0] header_offset;
		logic [7:0]  header_length;
	} out_item_t;

	typedef struct packed {
		logic [31:0] win;
		logic        seq_hit;
		logic [15:0] start;
		logic [3:0]  early_rec;
		logic [3:0]  late_rec;
	} scan_t;

	typedef struct packed {
		logic        ok;
		logic        err;
		logic        searching;
		logic [7:0]  length;
		logic [11:0] width;
		logic [11:0] height;
		logic [2:0]  profile;
		logic [1:0]  level;
		logic        ilace;
	} seq_t;

endpackage

### rtl/mhp_scan.sv
// Byte window, byte position, sequence start and picture start-code tracking
module mhp_scan #(
	parameter int MAX_BUFFER_BYTES = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  mhp_pkg::in_item_t item_s1,
	input  logic             searching,
	output mhp_pkg::scan_t   scan
);
	import mhp_pkg::*;

	localparam int POS_W = $clog2(MAX_BUFFER_BYTES);
	localparam int PX_W  = (POS_W > 16) ? POS_W : 16;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BUFFER_BYTES - 1);

	logic [31:0]      win_q;
	logic [POS_W-1:0] pos_q;
	logic [3:0]       early_q;
	logic [3:0]       late_q;
	logic [15:0]      start_q;

	logic [31:0]      win_n;
	logic [PX_W-1:0]  pos_ext;
	logic             pic_hit;
	logic             seq_hit;
	logic [3:0]       early_n;
	logic [3:0]       late_n;
	logic [15:0]      start_n;
	logic [POS_W-1:0] pos_n;

	function automatic logic [3:0] pic_update(input logic [3:0] r, input logic [7:0] b,
			input logic hit);
		logic [3:0] res;
		res = r;
		case (r)
			4'd0: res = hit ? 4'd1 : REC_NONE;
			4'd1: res = 4'd2;
			4'd2: res = {1'b1, b[5:3]};
			default: res = r;
		endcase
		return res;
	endfunction

	always_comb begin
		win_n   = {win_q[23:0], item_s1.data_byte};
		pos_ext = PX_W'(pos_q);
		pic_hit = !item_s1.last_byte && (win_n == CODE_PIC);
		seq_hit = searching && !item_s1.last_byte && (win_n == CODE_SEQ);
		early_n = searching ? pic_update(early_q, item_s1.data_byte, pic_hit) : early_q;
		late_n  = searching ? late_q : pic_update(late_q, item_s1.data_byte, pic_hit);
		start_n = seq_hit ? (pos_ext[15:0] - 16'(SC_BYTES - 1)) : start_q;
		pos_n   = (pos_q < POS_MAX) ? pos_q + POS_W'(1) : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '1;
			pos_q   <= '0;
			early_q <= REC_NONE;
			late_q  <= REC_NONE;
			start_q <= '0;
		end else if (step) begin
			if (item_s1.last_byte) begin
				win_q   <= '1;
				pos_q   <= '0;
				early_q <= REC_NONE;
				late_q  <= REC_NONE;
				start_q <= '0;
			end else begin
				win_q   <= win_n;
				pos_q   <= pos_n;
				early_q <= early_n;
				late_q  <= late_n;
				start_q <= start_n;
			end
		end
	end

	assign scan = '{win: win_n, seq_hit: seq_hit, start: start_n,
		early_rec: early_n, late_rec: late_n};

endmodule

### rtl/mhp_seq.sv
// Sequence header field parser, one byte per step
module mhp_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  mhp_pkg::in_item_t item_s1,
	input  mhp_pkg::scan_t   scan,
	output logic             searching,
	output mhp_pkg::seq_t    seq
);
	import mhp_pkg::*;

	typedef enum logic [7:0] {
		PH_SEARCH      = 8'b0000_0001,
		PH_FIELDS      = 8'b0000_0010,
		PH_MAT         = 8'b0000_0100,
		PH_EXT_CODE    = 8'b0000_1000,
		PH_EXT_BODY    = 8'b0001_0000,
		PH_OK_PLAIN    = 8'b0010_0000,
		PH_OK_EXT      = 8'b0100_0000,
		PH_MARKER_FAIL = 8'b1000_0000
	} phase_t;

	localparam logic [5:0] FLD_WIDTH   = 6'd1;
	localparam logic [5:0] FLD_HEIGHT  = 6'd2;
	localparam logic [5:0] FLD_FLAGS   = 6'd7;
	localparam logic [5:0] MAT_LAST    = 6'd63;
	localparam logic [5:0] EXT_CODE_END = 6'd3;
	localparam logic [5:0] EXT_ID      = 6'd4;
	localparam logic [5:0] BODY_LEVEL  = 6'd0;
	localparam logic [5:0] BODY_MARKER = 6'd2;
	localparam logic [5:0] BODY_END    = 6'd4;
	localparam logic [7:0] LEN_BASE    = 8'd12;
	localparam logic [7:0] LEN_MAT     = 8'd64;
	localparam logic [7:0] LEN_EXT     = 8'd10;
	localparam logic [3:0] EXT_ID_SEQ  = 4'd1;

	phase_t      phase_q, phase_n;
	logic [5:0]  cnt_q, cnt_n;
	logic        chk_q, chk_n;
	logic [7:0]  len_q, len_n;
	logic [11:0] width_q, width_n;
	logic [11:0] height_q, height_n;
	logic [2:0]  profile_q, profile_n;
	logic [1:0]  level_q, level_n;
	logic        ilace_q, ilace_n;
	logic [7:0]  b;

	function automatic logic [2:0] map_profile(input logic [2:0] p);
		logic [2:0] res;
		unique case (p)
			3'd5: res = 3'd0;
			3'd4: res = 3'd1;
			3'd3: res = 3'd2;
			3'd2: res = 3'd3;
			3'd1: res = 3'd4;
			default: res = 3'd0;
		endcase
		return res;
	endfunction

	function automatic logic [1:0] map_level(input logic [3:0] l);
		logic [1:0] res;
		unique case (l)
			4'd10: res = 2'd0;
			4'd8: res = 2'd1;
			4'd6: res = 2'd2;
			4'd4: res = 2'd3;
			default: res = 2'd0;
		endcase
		return res;
	endfunction

	always_comb begin
		b         = item_s1.data_byte;
		phase_n   = phase_q;
		cnt_n     = cnt_q + 6'd1;
		chk_n     = chk_q;
		len_n     = len_q;
		width_n   = width_q;
		height_n  = height_q;
		profile_n = profile_q;
		level_n   = level_q;
		ilace_n   = ilace_q;
		unique case (phase_q)
			PH_SEARCH: begin
				cnt_n = '0;
				if (scan.seq_hit) begin
					phase_n = PH_FIELDS;
					len_n   = LEN_BASE;
				end
			end
			PH_FIELDS: begin
				if (cnt_q == FLD_WIDTH)
					width_n = {scan.win[15:8], b[7:4]};
				if (cnt_q == FLD_HEIGHT)
					height_n = {scan.win[11:8], b};
				if (cnt_q == FLD_FLAGS) begin
					cnt_n = '0;
					if (b[1]) begin
						phase_n = PH_MAT;
						chk_n   = 1'b1;
						len_n   = len_q + LEN_MAT;
					end else if (b[0]) begin
						phase_n = PH_MAT;
						chk_n   = 1'b0;
						len_n   = len_q + LEN_MAT;
					end else begin
						phase_n = PH_EXT_CODE;
					end
				end
			end
			PH_MAT: begin
				if (cnt_q == MAT_LAST) begin
					cnt_n = '0;
					if (chk_q && b[0]) begin
						chk_n = 1'b0;
						len_n = len_q + LEN_MAT;
					end else begin
						phase_n = PH_EXT_CODE;
					end
				end
			end
			PH_EXT_CODE: begin
				if (cnt_q == EXT_CODE_END && scan.win != CODE_EXT)
					phase_n = PH_OK_PLAIN;
				if (cnt_q == EXT_ID) begin
					if (b[7:4] == EXT_ID_SEQ) begin
						phase_n   = PH_EXT_BODY;
						cnt_n     = '0;
						profile_n = map_profile(b[2:0]);
					end else begin
						phase_n = PH_OK_PLAIN;
					end
				end
			end
			PH_EXT_BODY: begin
				if (cnt_q == BODY_LEVEL) begin
					level_n = map_level(b[7:4]);
					ilace_n = !b[3];
				end
				if (cnt_q == BODY_MARKER && !b[0])
					phase_n = PH_MARKER_FAIL;
				if (cnt_q == BODY_END)
					phase_n = PH_OK_EXT;
			end
			PH_OK_PLAIN, PH_OK_EXT, PH_MARKER_FAIL: begin
				cnt_n = cnt_q;
			end
			default: begin
				phase_n = PH_SEARCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SEARCH;
			cnt_q     <= '0;
			chk_q     <= 1'b0;
			len_q     <= LEN_BASE;
			width_q   <= '0;
			height_q  <= '0;
			profile_q <= '0;
			level_q   <= '0;
			ilace_q   <= 1'b0;
		end else if (step) begin
			width_q   <= width_n;
			height_q  <= height_n;
			profile_q <= profile_n;
			level_q   <= level_n;
			ilace_q   <= ilace_n;
			if (item_s1.last_byte) begin
				phase_q <= PH_SEARCH;
				cnt_q   <= '0;
				chk_q   <= 1'b0;
				len_q   <= LEN_BASE;
			end else begin
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
				chk_q   <= chk_n;
				len_q   <= len_n;
			end
		end
	end

	assign searching = (phase_q == PH_SEARCH);

	always_comb begin
		seq.ok        = (phase_n == PH_EXT_CODE) || (phase_n == PH_OK_PLAIN)
			|| (phase_n == PH_OK_EXT);
		seq.err       = (phase_n == PH_FIELDS) || (phase_n == PH_MAT)
			|| (phase_n == PH_EXT_BODY);
		seq.searching = (phase_n == PH_SEARCH);
		seq.length    = len_n + ((phase_n == PH_OK_EXT) ? LEN_EXT : 8'd0);
		seq.width     = width_n;
		seq.height    = height_n;
		seq.profile   = profile_n;
		seq.level     = level_n;
		seq.ilace     = ilace_n;
	end

endmodule

### rtl/mhp_out.sv
// Buffer-end status decision, carried picture fields and result register
module mhp_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  mhp_pkg::in_item_t  item_s1,
	input  mhp_pkg::scan_t    scan,
	input  mhp_pkg::seq_t     seq,
	output logic              result_valid,
	input  logic              result_ready,
	output mhp_pkg::out_item_t result
);
	import mhp_pkg::*;

	localparam logic [2:0] PT_I = 3'd1;
	localparam logic [2:0] PT_B = 3'd3;

	logic        ever_q;
	logic [15:0] offset_q;
	logic [7:0]  length_q;
	logic [1:0]  ftype_q;
	logic        ref_q;
	logic        valid_q;
	out_item_t   res_q;

	logic [3:0]  rec;
	logic [2:0]  ptype;
	logic        pic_ok;
	logic        pic_err;
	logic        ever_n;
	logic [15:0] offset_n;
	logic [7:0]  length_n;
	logic [1:0]  ftype_n;
	logic        ref_n;
	logic [2:0]  status;
	logic        load;

	always_comb begin
		rec      = seq.searching ? scan.early_rec : scan.late_rec;
		ptype    = rec[2:0];
		pic_ok   = !seq.err && rec[3] && (ptype >= PT_I) && (ptype <= PT_B);
		pic_err  = !seq.err && (rec != REC_NONE) && !pic_ok;
		ever_n   = ever_q || seq.ok;
		offset_n = seq.ok ? scan.start : offset_q;
		length_n = seq.ok ? seq.length : length_q;
		ftype_n  = pic_ok ? (ptype[1:0] - 2'd1) : ftype_q;
		ref_n    = pic_ok ? (ptype != PT_B) : ref_q;
		if (seq.err)
			status = ST_SEQ_ERR;
		else if (pic_err)
			status = ST_PIC_ERR;
		else if (seq.ok && pic_ok)
			status = ST_SEQ_PIC;
		else if (seq.ok)
			status = ST_SEQ_ONLY;
		else if (pic_ok)
			status = ST_PIC_ONLY;
		else
			status = ST_NONE;
		load = step && item_s1.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ever_q   <= 1'b0;
			offset_q <= '0;
			length_q <= '0;
			ftype_q  <= '0;
			ref_q    <= 1'b0;
			valid_q  <= 1'b0;
		end else if (load) begin
			ever_q   <= ever_n;
			offset_q <= offset_n;
			length_q <= length_n;
			ftype_q  <= ftype_n;
			ref_q    <= ref_n;
			valid_q  <= 1'b1;
		end else if (result_ready) begin
			valid_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= '{status: status, seq_valid: ever_n, pic_valid: pic_ok,
				frame_width: seq.width, frame_height: seq.height,
				profile_code: seq.profile, level_code: seq.level,
				interlaced: seq.ilace, frame_type: ftype_n, is_reference: ref_n,
				header_offset: offset_n, header_length: length_n};
		end
	end

	assign result_valid = valid_q;
	assign result       = res_q;

endmodule

### rtl/mpeg2_header_parser.sv
// MPEG-2 sequence and picture header parser top level
//
//  channel  | signals                            | payload
//  ---------+------------------------------------+-------------------------------
//  item     | item_valid / item_ready            | data_byte, last_byte
//  result   | result_valid / result_ready        | status and kept header fields
//
// One byte per cycle while the parse stage is not waiting on a pending result: bytes
// pass an input register, then window shift and field-phase logic, and the result
// register loads once the parse stage accepts the last byte. Reset clears all per-buffer and kept state.
// A pending result holds in the output register; bytes keep flowing until the
// next last byte reaches the parse stage, which then waits for the result transfer.
`include "mpeg2_header_parser_macros.svh"

module mpeg2_header_parser #(
	parameter int MAX_BUFFER_BYTES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  mhp_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output mhp_pkg::out_item_t result
);
	import mhp_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;
	logic     step;
	logic     searching;
	scan_t    scan;
	seq_t     seq;

	assign step       = valid_s1 && (!item_s1.last_byte || !result_valid || result_ready);
	assign item_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	mhp_scan #(
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item_s1   (item_s1),
		.searching (searching),
		.scan      (scan)
	);

	mhp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item_s1   (item_s1),
		.scan      (scan),
		.searching (searching),
		.seq       (seq)
	);

	mhp_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.item_s1      (item_s1),
		.scan         (scan),
		.seq          (seq),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	`MHP_ASSERT_NEXT(a_last_gives_result, step && item_s1.last_byte, result_valid,
		"last byte did not produce a result")
	`MHP_ASSERT_NOW(a_no_overwrite, result_valid && !result_ready,
		!(step && item_s1.last_byte), "pending result overwritten")
	`MHP_ASSERT_NOW(a_seq_err_no_pic, result_valid && result.status == ST_SEQ_ERR,
		!result.pic_valid, "picture reported valid with a sequence error")
	`MHP_ASSERT_NOW(a_pic_status, result_valid && result.pic_valid,
		result.status == ST_SEQ_PIC || result.status == ST_PIC_ONLY,
		"picture valid with a status that excludes it")

endmodule
